/* design/swrf_pkg.sv */
`default_nettype none

package swrf_pkg;

    localparam int FRAC_BITS = 16;
    localparam int PEN_EPS   = 66;

    localparam int WORD_W  = 32;
    localparam int DEPTH_W = WORD_W + 2;
    // product widths after dropping the fraction bits
    localparam int SPR_W   = 63 - FRAC_BITS;
    localparam int DMP_W   = 64 - FRAC_BITS;
    localparam int KIN_W   = 50 - FRAC_BITS;
    localparam int ACC_W   = 52;

    typedef logic signed [WORD_W-1:0] t_word;
    typedef logic signed [ACC_W-1:0]  t_acc;

    typedef enum logic [2:0] {
        REG_BOX_X        = 3'd0,
        REG_BOX_Y        = 3'd1,
        REG_BOX_Z        = 3'd2,
        REG_WALL_DIST    = 3'd3,
        REG_STIFFNESS    = 3'd4,
        REG_DAMPING      = 3'd5,
        REG_KINETIC      = 3'd6,
        REG_STATIC_LIMIT = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [2:0][30:0] box;
        logic [30:0]      wall_dist;
        logic [30:0]      stiff;
        logic [30:0]      damp;
        logic [16:0]      kin;
        logic [31:0]      static_lim;
    } t_cfg;

    typedef struct packed {
        t_word [2:0] pos;
        t_word [2:0] vel;
        t_word [2:0] frc;
    } t_part;

    typedef struct packed {
        logic [2:0][31:0] dep_lo;
        logic [2:0][31:0] dep_hi;
        logic [2:0]       act_lo;
        logic [2:0]       act_hi;
        logic [2:0]       slide;
        t_word [2:0]      vel;
        t_word [2:0]      frc;
    } t_s2;

    typedef struct packed {
        logic [2:0][SPR_W-1:0] spr_lo;
        logic [2:0][SPR_W-1:0] spr_hi;
        logic [2:0][DMP_W-1:0] dmp_fl;
        logic [2:0]            dmp_frac;
        logic [2:0][KIN_W-1:0] kin_fl;
        logic [2:0]            kin_frac;
        logic [2:0]            act_lo;
        logic [2:0]            act_hi;
        logic [2:0]            slide;
        t_word [2:0]           vel;
        t_word [2:0]           frc;
    } t_s3;

    typedef struct packed {
        t_acc [2:0]  wall;
        t_acc [2:0]  fric;
        t_word [2:0] frc;
    } t_s4;

    localparam t_acc SAT_MAX = t_acc'(64'sd2147483647);
    localparam t_acc SAT_MIN = t_acc'(-64'sd2147483648);

endpackage

`default_nettype wire

/* design/swrf_if.sv */
`default_nettype none

interface swrf_part_if;
    logic                valid;
    logic                ready;
    logic signed [31:0]  pos_x;
    logic signed [31:0]  pos_y;
    logic signed [31:0]  pos_z;
    logic signed [31:0]  vel_x;
    logic signed [31:0]  vel_y;
    logic signed [31:0]  vel_z;
    logic signed [31:0]  force_in_x;
    logic signed [31:0]  force_in_y;
    logic signed [31:0]  force_in_z;

    modport source (
        output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
               force_in_x, force_in_y, force_in_z,
        input  ready
    );
    modport sink (
        input  valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
               force_in_x, force_in_y, force_in_z,
        output ready
    );
endinterface

interface swrf_force_if;
    logic                valid;
    logic                ready;
    logic signed [31:0]  force_out_x;
    logic signed [31:0]  force_out_y;
    logic signed [31:0]  force_out_z;

    modport source (
        output valid, force_out_x, force_out_y, force_out_z,
        input  ready
    );
    modport sink (
        input  valid, force_out_x, force_out_y, force_out_z,
        output ready
    );
endinterface

interface swrf_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

`default_nettype wire

/* design/swrf_depth.sv */
`default_nettype none

module swrf_depth (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_en,
    input  wire                  i_valid,
    input  wire swrf_pkg::t_part i_part,
    input  wire swrf_pkg::t_cfg  i_cfg,
    output logic                 o_valid,
    output swrf_pkg::t_s2        o_s2
);

    localparam int DW = swrf_pkg::DEPTH_W;
    localparam logic signed [DW-1:0] EPS = DW'(swrf_pkg::PEN_EPS);

    logic signed [DW-1:0] w_wd;
    logic signed [DW-1:0] w_sl;
    logic signed [DW-1:0] w_lim3;
    logic signed [DW-1:0] w_pos [3];
    logic signed [DW-1:0] w_vel [3];
    logic signed [DW-1:0] w_dlo [3];
    logic signed [DW-1:0] w_dhi [3];
    logic signed [DW-1:0] w_tsum [3];

    swrf_pkg::t_s2 n_s2;
    swrf_pkg::t_s2 r_s2;
    logic          r_valid;

    always_comb begin
        w_wd   = $signed({3'b000, i_cfg.wall_dist});
        w_sl   = $signed({{2{i_cfg.static_lim[31]}}, i_cfg.static_lim});
        w_lim3 = w_sl + (w_sl <<< 1);
        for (int a = 0; a < 3; a++) begin
            w_pos[a] = $signed({{2{i_part.pos[a][31]}}, i_part.pos[a]});
            w_vel[a] = $signed({{2{i_part.vel[a][31]}}, i_part.vel[a]});
        end
        n_s2 = '0;
        for (int a = 0; a < 3; a++) begin
            // lower wall: distance is pos; upper wall: distance is box - pos
            w_dlo[a]  = w_wd - w_pos[a];
            w_dhi[a]  = w_wd - $signed({3'b000, i_cfg.box[a]}) + w_pos[a];
            w_tsum[a] = w_vel[(a == 2) ? 0 : a + 1] + w_vel[(a == 0) ? 2 : a - 1];
            n_s2.dep_lo[a] = w_dlo[a][31:0];
            n_s2.dep_hi[a] = w_dhi[a][31:0];
            n_s2.act_lo[a] = w_dlo[a] > EPS;
            n_s2.act_hi[a] = w_dhi[a] > EPS;
            // sliding: sum of the other two axes' velocities compared against three times the limit
            n_s2.slide[a]  = w_tsum[a] > w_lim3;
        end
        n_s2.vel = i_part.vel;
        n_s2.frc = i_part.frc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && i_valid) begin
            r_s2 <= n_s2;
        end
    end

    assign o_valid = r_valid;
    assign o_s2    = r_s2;

endmodule

`default_nettype wire

/* design/swrf_mult.sv */
`default_nettype none

module swrf_mult (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_en,
    input  wire                 i_valid,
    input  wire swrf_pkg::t_s2  i_s2,
    input  wire swrf_pkg::t_cfg i_cfg,
    output logic                o_valid,
    output swrf_pkg::t_s3       o_s3
);

    localparam int FB = swrf_pkg::FRAC_BITS;

    logic [62:0]        w_spr_lo [3];
    logic [62:0]        w_spr_hi [3];
    logic signed [63:0] w_dmp [3];
    logic signed [49:0] w_kin [3];

    swrf_pkg::t_s3 n_s3;
    swrf_pkg::t_s3 r_s3;
    logic          r_valid;

    always_comb begin
        n_s3 = '0;
        for (int a = 0; a < 3; a++) begin
            w_spr_lo[a] = i_cfg.stiff * i_s2.dep_lo[a];
            w_spr_hi[a] = i_cfg.stiff * i_s2.dep_hi[a];
            w_dmp[a]    = $signed({1'b0, i_cfg.damp}) * $signed(i_s2.vel[a]);
            w_kin[a]    = $signed({1'b0, i_cfg.kin}) * $signed(i_s2.vel[a]);
            // upper bits give the floor; the fraction flag turns it into a ceiling later
            n_s3.spr_lo[a]   = w_spr_lo[a][62:FB];
            n_s3.spr_hi[a]   = w_spr_hi[a][62:FB];
            n_s3.dmp_fl[a]   = w_dmp[a][63:FB];
            n_s3.dmp_frac[a] = |w_dmp[a][FB-1:0];
            n_s3.kin_fl[a]   = w_kin[a][49:FB];
            n_s3.kin_frac[a] = |w_kin[a][FB-1:0];
        end
        n_s3.act_lo = i_s2.act_lo;
        n_s3.act_hi = i_s2.act_hi;
        n_s3.slide  = i_s2.slide;
        n_s3.vel    = i_s2.vel;
        n_s3.frc    = i_s2.frc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && i_valid) begin
            r_s3 <= n_s3;
        end
    end

    assign o_valid = r_valid;
    assign o_s3    = r_s3;

endmodule

`default_nettype wire

/* design/swrf_combine.sv */
`default_nettype none

module swrf_combine (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_en,
    input  wire                i_valid,
    input  wire swrf_pkg::t_s3 i_s3,
    output logic               o_valid,
    output swrf_pkg::t_s4      o_s4
);

    swrf_pkg::t_acc w_kfr [3];
    swrf_pkg::t_acc w_wall [3];
    swrf_pkg::t_acc w_fric [3];
    swrf_pkg::t_acc w_term;

    swrf_pkg::t_s4 n_s4;
    swrf_pkg::t_s4 r_s4;
    logic          r_valid;

    always_comb begin
        w_term = '0;
        for (int k = 0; k < 3; k++) begin
            // kinetic term: floor(-kf*v) = -ceil(kf*v)
            w_kfr[k] = -(swrf_pkg::t_acc'($signed(i_s3.kin_fl[k]))
                         + swrf_pkg::t_acc'(i_s3.kin_frac[k]));
        end
        for (int a = 0; a < 3; a++) begin
            w_wall[a] = '0;
            if (i_s3.act_lo[a]) begin
                w_wall[a] = w_wall[a] + swrf_pkg::t_acc'(i_s3.spr_lo[a])
                            - swrf_pkg::t_acc'($signed(i_s3.dmp_fl[a]));
            end
            // upper wall, inward normal negative: -(spring + ceil(damping * v))
            if (i_s3.act_hi[a]) begin
                w_wall[a] = w_wall[a] - swrf_pkg::t_acc'(i_s3.spr_hi[a])
                            - swrf_pkg::t_acc'($signed(i_s3.dmp_fl[a]))
                            - swrf_pkg::t_acc'(i_s3.dmp_frac[a]);
            end
        end
        for (int k = 0; k < 3; k++) begin
            w_fric[k] = '0;
            for (int a = 0; a < 3; a++) begin
                if (a != k) begin
                    w_term = i_s3.slide[a] ? -swrf_pkg::t_acc'($signed(i_s3.vel[k]))
                                           : w_kfr[k];
                    if (i_s3.act_lo[a]) begin
                        w_fric[k] = w_fric[k] + w_term;
                    end
                    if (i_s3.act_hi[a]) begin
                        w_fric[k] = w_fric[k] + w_term;
                    end
                end
            end
        end
        for (int k = 0; k < 3; k++) begin
            n_s4.wall[k] = w_wall[k];
            n_s4.fric[k] = w_fric[k];
        end
        n_s4.frc = i_s3.frc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && i_valid) begin
            r_s4 <= n_s4;
        end
    end

    assign o_valid = r_valid;
    assign o_s4    = r_s4;

endmodule

`default_nettype wire

/* design/swrf_sat.sv */
`default_nettype none

module swrf_sat (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_en,
    input  wire                   i_valid,
    input  wire swrf_pkg::t_s4    i_s4,
    output logic                  o_valid,
    output swrf_pkg::t_word [2:0] o_force
);

    swrf_pkg::t_acc          w_sum [3];
    swrf_pkg::t_word [2:0]   n_force;
    swrf_pkg::t_word [2:0]   r_force;
    logic                    r_valid;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_sum[k] = swrf_pkg::t_acc'($signed(i_s4.frc[k])) + i_s4.wall[k] + i_s4.fric[k];
            if (w_sum[k] > swrf_pkg::SAT_MAX) begin
                n_force[k] = swrf_pkg::SAT_MAX[31:0];
            end else if (w_sum[k] < swrf_pkg::SAT_MIN) begin
                n_force[k] = swrf_pkg::SAT_MIN[31:0];
            end else begin
                n_force[k] = w_sum[k][31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && i_valid) begin
            r_force <= n_force;
        end
    end

    assign o_valid = r_valid;
    assign o_force = r_force;

endmodule

`default_nettype wire

/* design/sph_wall_repulsion_friction_core.sv */
// Wall repulsion and friction for one particle per transfer.
// i_part: position, velocity and accumulated force of a particle (Q16.16).
// o_force: the force with the six wall terms and friction added, saturated.
// i_cfg: register writes (index, data); always ready, write only while idle.
// Five register stages: input, depth/limits, multipliers, term sums, saturate.
// Throughput: one particle per cycle unless o_force stalls; every stage has
// its own valid bit and moves when the stage after it is empty or moving, so
// bubbles close up and a new particle is taken while a finished result is
// still waiting.
// A stalled receiver holds o_force; i_part.ready drops only once all five
// stages are full.
// Reset (synchronous, active low) empties the pipeline and sets the box
// sizes to 1.0 and all other registers to zero.
`default_nettype none

module sph_wall_repulsion_friction_core (
    input  wire          i_clk,
    input  wire          i_rst_n,
    swrf_cfg_if.sink     i_cfg,
    swrf_part_if.sink    i_part,
    swrf_force_if.source o_force
);

    swrf_pkg::t_cfg        r_cfg;
    swrf_pkg::t_part       n_in;
    swrf_pkg::t_part       r_in;
    logic                  r_v1;
    swrf_pkg::t_s2         w_s2;
    swrf_pkg::t_s3         w_s3;
    swrf_pkg::t_s4         w_s4;
    swrf_pkg::t_word [2:0] w_force;
    logic                  w_v2;
    logic                  w_v3;
    logic                  w_v4;
    logic                  w_v5;
    logic                  w_en1;
    logic                  w_en2;
    logic                  w_en3;
    logic                  w_en4;
    logic                  w_en5;

    // configuration registers
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.box        <= {3{31'd65536}};
            r_cfg.wall_dist  <= '0;
            r_cfg.stiff      <= '0;
            r_cfg.damp       <= '0;
            r_cfg.kin        <= '0;
            r_cfg.static_lim <= '0;
        end else if (i_cfg.valid) begin
            case (swrf_pkg::t_reg_idx'(i_cfg.index))
                swrf_pkg::REG_BOX_X:        r_cfg.box[0]     <= i_cfg.data[30:0];
                swrf_pkg::REG_BOX_Y:        r_cfg.box[1]     <= i_cfg.data[30:0];
                swrf_pkg::REG_BOX_Z:        r_cfg.box[2]     <= i_cfg.data[30:0];
                swrf_pkg::REG_WALL_DIST:    r_cfg.wall_dist  <= i_cfg.data[30:0];
                swrf_pkg::REG_STIFFNESS:    r_cfg.stiff      <= i_cfg.data[30:0];
                swrf_pkg::REG_DAMPING:      r_cfg.damp       <= i_cfg.data[30:0];
                swrf_pkg::REG_KINETIC:      r_cfg.kin        <= i_cfg.data[16:0];
                swrf_pkg::REG_STATIC_LIMIT: r_cfg.static_lim <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    // stage enables, back to front
    assign w_en5        = !w_v5 || o_force.ready;
    assign w_en4        = !w_v4 || w_en5;
    assign w_en3        = !w_v3 || w_en4;
    assign w_en2        = !w_v2 || w_en3;
    assign w_en1        = !r_v1 || w_en2;
    assign i_part.ready = w_en1;

    always_comb begin
        n_in.pos[0] = i_part.pos_x;
        n_in.pos[1] = i_part.pos_y;
        n_in.pos[2] = i_part.pos_z;
        n_in.vel[0] = i_part.vel_x;
        n_in.vel[1] = i_part.vel_y;
        n_in.vel[2] = i_part.vel_z;
        n_in.frc[0] = i_part.force_in_x;
        n_in.frc[1] = i_part.force_in_y;
        n_in.frc[2] = i_part.force_in_z;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_en1) begin
            r_v1 <= i_part.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1 && i_part.valid) begin
            r_in <= n_in;
        end
    end

    swrf_depth u_depth (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en2),
        .i_valid (r_v1),
        .i_part  (r_in),
        .i_cfg   (r_cfg),
        .o_valid (w_v2),
        .o_s2    (w_s2)
    );

    swrf_mult u_mult (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en3),
        .i_valid (w_v2),
        .i_s2    (w_s2),
        .i_cfg   (r_cfg),
        .o_valid (w_v3),
        .o_s3    (w_s3)
    );

    swrf_combine u_combine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en4),
        .i_valid (w_v3),
        .i_s3    (w_s3),
        .o_valid (w_v4),
        .o_s4    (w_s4)
    );

    swrf_sat u_sat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en5),
        .i_valid (w_v4),
        .i_s4    (w_s4),
        .o_valid (w_v5),
        .o_force (w_force)
    );

    assign o_force.valid       = w_v5;
    assign o_force.force_out_x = w_force[0];
    assign o_force.force_out_y = w_force[1];
    assign o_force.force_out_z = w_force[2];

`ifndef SYNTH
    // back-pressure reaches the input only when every stage holds a particle
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_part.ready |-> (r_v1 && w_v2 && w_v3 && w_v4 && w_v5))
        else $error("input stalled with an empty stage");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_v4 && w_en5) |=> o_force.valid)
        else $error("result lost between sum and output stage");

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_force.valid)
        else $error("result offered straight after reset");
`endif

endmodule

`default_nettype wire
